[sv/cti_pkg.sv]
// Package: shared field widths, status codes and types of the table interpolator.
`default_nettype none
package cti_pkg;
	localparam int WL_W = 20;
	localparam int N_W  = 20;
	localparam int K_W  = 24;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int ENT_W = WL_W + N_W + K_W;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DESC     = 2'd1,
		ST_NOTREADY = 2'd2,
		ST_SEQ      = 2'd3
	} status_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] ADDR_ENTRIES = 3'd0;

	typedef struct packed {
		logic [K_W-1:0]  k;
		logic [N_W-1:0]  n;
		logic [WL_W-1:0] wl;
	} entry_t;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_FIRST  = 12'b000000000010,
		S_LAST   = 12'b000000000100,
		S_SISSUE = 12'b000000001000,
		S_SCMP   = 12'b000000010000,
		S_GET0   = 12'b000000100000,
		S_GET1   = 12'b000001000000,
		S_DIV    = 12'b000010000000,
		S_MULN   = 12'b000100000000,
		S_ADDN   = 12'b001000000000,
		S_ADDK   = 12'b010000000000,
		S_FIN    = 12'b100000000000
	} state_t;
endpackage
`default_nettype wire

[sv/cti_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cti_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[sv/clamped_table_interpolator.sv]
// Top level: clamped piecewise-linear table interpolator with table RAM and sequencer.
//
// Channel  | Dir | Beat contents
// s_*      | in  | tuser: command; tdata: entry_index, wavelength, real_index_in, extinction_in
// m_*      | out | tuser: status; tdata: real_index_out, extinction_out
// APB      | cfg | register 0 at 0x0: entries_in_use (7 bits)
//
// A load is accepted, then its status goes to the result register. A query reads
// entry 0 and the last entry in use for the clamps, then does one RAM read per
// binary-search step, runs a restoring divider that yields 16 quotient bits and
// makes two passes through one shared multiplier. The sequencer returns to idle
// before the next accept. Clamped, not-ready and exact-entry hits end early.
// Reset clears control and counters only; the table RAM is not cleared.
// One item is in flight; a finished result waits in the output register and
// the sequencer holds in its final state until that register frees up.
`default_nettype none
module clamped_table_interpolator #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [5:0] entry_index, [25:6] wavelength, [45:26] real_index_in, [69:46] extinction_in
	input  wire logic [71:0] s_tdata,
	// [0] command
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [19:0] real_index_out, [43:20] extinction_out
	output logic [47:0]      m_tdata,
	// [1:0] status
	output logic [1:0]       m_tuser,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int MW = AW + 1;
	localparam int CW = AW + 8;
	localparam int WL_W = cti_pkg::WL_W;
	localparam int N_W = cti_pkg::N_W;
	localparam int K_W = cti_pkg::K_W;
	localparam int PW = 42;   // 17 x 25 signed product

	// configuration
	logic [cti_pkg::CNT_W-1:0] entries_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= cti_pkg::CNT_W'(2);
		end else if (psel && penable && pwrite && paddr == cti_pkg::ADDR_ENTRIES) begin
			entries_q <= pwdata[cti_pkg::CNT_W-1:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == cti_pkg::ADDR_ENTRIES) begin
			prdata = {{(32 - cti_pkg::CNT_W){1'b0}}, entries_q};
		end
	end

	// input fields
	logic [cti_pkg::IDX_W-1:0] in_idx;
	logic [WL_W-1:0] in_wl;
	logic [N_W-1:0]  in_n;
	logic [K_W-1:0]  in_k;
	assign in_idx = s_tdata[5:0];
	assign in_wl  = s_tdata[25:6];
	assign in_n   = s_tdata[45:26];
	assign in_k   = s_tdata[69:46];

	// effective entry count, clamped to 2..TABLE_DEPTH
	logic [CW-1:0] ent_ext;
	logic [MW-1:0] m_eff;
	assign ent_ext = CW'(entries_q);
	always_comb begin
		priority if (ent_ext < CW'(2)) begin
			m_eff = MW'(2);
		end else if (ent_ext > CW'(TABLE_DEPTH)) begin
			m_eff = MW'(TABLE_DEPTH);
		end else begin
			m_eff = ent_ext[MW-1:0];
		end
	end

	cti_pkg::state_t state_q;
	logic [cti_pkg::CNT_W-1:0] filled_q;
	logic                      asc_q;
	logic [WL_W-1:0]           last_wl_q;
	logic [WL_W-1:0]           q_q;
	logic [MW-1:0]             m_q;
	logic [AW-1:0]             lo_q, hi_q;
	logic [WL_W-1:0]           w0_q;
	logic [N_W-1:0]            n0_q, n1_q;
	logic [K_W-1:0]            k0_q, k1_q;
	logic [WL_W:0]             rem_q;
	logic [WL_W-1:0]           den_q;
	logic [15:0]               t_q;
	logic [3:0]                cnt_q;
	logic signed [PW-1:0]      prod_q;
	logic [N_W-1:0]            res_n_q;
	logic [K_W-1:0]            res_k_q;
	cti_pkg::status_t          res_st_q;

	logic accept;
	assign s_tready = (state_q == cti_pkg::S_IDLE);
	assign accept = s_tvalid && s_tready;

	// load checks
	logic [CW-1:0] idx_ext;
	logic seq_ok, desc, ready_ok;
	assign idx_ext = CW'(in_idx);
	assign seq_ok = (in_idx == '0 || idx_ext == CW'(filled_q)) && idx_ext < CW'(TABLE_DEPTH);
	assign desc = (in_idx != '0) && (in_wl < last_wl_q);
	assign ready_ok = asc_q && (CW'(filled_q) >= CW'(m_eff));

	// table RAM
	logic             ram_we;
	logic [AW-1:0]    ram_raddr;
	cti_pkg::entry_t  ram_wdata, ram_rdata;
	assign ram_we = accept && s_tuser == cti_pkg::CMD_LOAD && seq_ok;
	assign ram_wdata = '{k: in_k, n: in_n, wl: in_wl};

	logic [AW-1:0] mid, last_idx;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign last_idx = AW'(m_q - MW'(1));

	always_comb begin
		unique case (state_q)
			cti_pkg::S_FIRST:  ram_raddr = last_idx;
			cti_pkg::S_SISSUE: ram_raddr = (lo_q < hi_q) ? mid : lo_q - AW'(1);
			cti_pkg::S_GET0:   ram_raddr = lo_q;
			default:           ram_raddr = '0;
		endcase
	end

	cti_ram #(.WIDTH(cti_pkg::ENT_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// divider step and shared multiplier
	logic [WL_W:0] rem_sh;
	assign rem_sh = {rem_q[WL_W-1:0], 1'b0};
	logic signed [24:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [25:0] shr;
	always_comb begin
		if (state_q == cti_pkg::S_MULN) begin
			mul_b = 25'($signed({1'b0, n1_q}) - $signed({1'b0, n0_q}));
		end else begin
			mul_b = $signed({1'b0, k1_q}) - $signed({1'b0, k0_q});
		end
	end
	assign mul_p = $signed({1'b0, t_q}) * mul_b;
	assign shr = 26'(prod_q >>> 16);   // arithmetic shift: floor

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cti_pkg::S_IDLE;
			filled_q  <= '0;
			asc_q     <= 1'b0;
			last_wl_q <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			// the final state reloads the output register itself
			if (m_tvalid && m_tready && state_q != cti_pkg::S_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				cti_pkg::S_IDLE: begin
					if (accept) begin
						q_q <= in_wl;
						m_q <= m_eff;
						res_n_q <= '0;
						res_k_q <= '0;
						if (s_tuser == cti_pkg::CMD_LOAD) begin
							state_q <= cti_pkg::S_FIN;
							if (!seq_ok) begin
								res_st_q <= cti_pkg::ST_SEQ;
								if (in_idx == '0) begin
									filled_q <= '0;
									asc_q <= 1'b1;
								end
							end else begin
								filled_q  <= cti_pkg::CNT_W'(in_idx) + cti_pkg::CNT_W'(1);
								last_wl_q <= in_wl;
								if (desc) begin
									asc_q <= 1'b0;
									res_st_q <= cti_pkg::ST_DESC;
								end else begin
									if (in_idx == '0) begin
										asc_q <= 1'b1;
									end
									res_st_q <= cti_pkg::ST_OK;
								end
							end
						end else if (!ready_ok) begin
							res_st_q <= cti_pkg::ST_NOTREADY;
							state_q <= cti_pkg::S_FIN;
						end else begin
							res_st_q <= cti_pkg::ST_OK;
							state_q <= cti_pkg::S_FIRST;
						end
					end
				end
				cti_pkg::S_FIRST: begin
					// entry 0 on the read port; clamp low
					if (q_q <= ram_rdata.wl) begin
						res_n_q <= ram_rdata.n;
						res_k_q <= ram_rdata.k;
						state_q <= cti_pkg::S_FIN;
					end else begin
						state_q <= cti_pkg::S_LAST;
					end
				end
				cti_pkg::S_LAST: begin
					// last entry in use; clamp high
					if (q_q >= ram_rdata.wl) begin
						res_n_q <= ram_rdata.n;
						res_k_q <= ram_rdata.k;
						state_q <= cti_pkg::S_FIN;
					end else begin
						lo_q <= '0;
						hi_q <= last_idx;
						state_q <= cti_pkg::S_SISSUE;
					end
				end
				cti_pkg::S_SISSUE: begin
					state_q <= (lo_q < hi_q) ? cti_pkg::S_SCMP : cti_pkg::S_GET0;
				end
				cti_pkg::S_SCMP: begin
					if (ram_rdata.wl < q_q) begin
						lo_q <= mid + AW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= cti_pkg::S_SISSUE;
				end
				cti_pkg::S_GET0: begin
					w0_q <= ram_rdata.wl;
					n0_q <= ram_rdata.n;
					k0_q <= ram_rdata.k;
					state_q <= cti_pkg::S_GET1;
				end
				cti_pkg::S_GET1: begin
					if (q_q == ram_rdata.wl) begin
						// query lands on the upper entry: t is one, result is that entry
						res_n_q <= ram_rdata.n;
						res_k_q <= ram_rdata.k;
						state_q <= cti_pkg::S_FIN;
					end else begin
						n1_q  <= ram_rdata.n;
						k1_q  <= ram_rdata.k;
						den_q <= ram_rdata.wl - w0_q;
						rem_q <= {1'b0, q_q - w0_q};
						t_q   <= '0;
						cnt_q <= '0;
						state_q <= cti_pkg::S_DIV;
					end
				end
				cti_pkg::S_DIV: begin
					// restoring division, one quotient bit a cycle
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						t_q <= {t_q[14:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						t_q <= {t_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= cti_pkg::S_MULN;
					end
				end
				cti_pkg::S_MULN: begin
					prod_q <= mul_p;
					state_q <= cti_pkg::S_ADDN;
				end
				cti_pkg::S_ADDN: begin
					res_n_q <= N_W'(26'($signed({6'b0, n0_q})) + shr);
					prod_q <= mul_p;
					state_q <= cti_pkg::S_ADDK;
				end
				cti_pkg::S_ADDK: begin
					res_k_q <= K_W'(26'($signed({2'b0, k0_q})) + shr);
					state_q <= cti_pkg::S_FIN;
				end
				cti_pkg::S_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {4'b0, res_k_q, res_n_q};
						m_tuser  <= res_st_q;
						state_q  <= cti_pkg::S_IDLE;
					end
				end
				default: state_q <= cti_pkg::S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
